// File: src/bbc_lru_pkg.sv
// shared types and constants of the lru block buffer cache slot manager
package bbc_lru_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int KIND_W         = 2;
  localparam int DEV_W          = 8;
  localparam int BLK_W          = 32;
  localparam int SLOT_W         = 5;
  localparam int CNT_W          = 8;
  localparam int STATUS_W       = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_GET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIN     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNPIN   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BUF    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic                hit;
    logic                needs_fill;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

// File: src/block_buffer_cache_lru.sv
// lru block buffer cache slot manager with reference counts
//
// After reset the block runs an init pass that writes every slot (busy_o high). A request
// transfer happens on a rising edge with start_i high and busy_o low. All slot state sits
// in one memory with one read and one write port, and a single compare unit walks it one
// slot per cycle: a get scans every slot with busy_o high, a release that brings the
// count to zero sweeps the ranks in the same way, other pin, unpin and release requests
// are handled in the ST_OP state, and a pin, unpin or release on a slot beyond the cache
// never raises busy_o. The result shows on rsp_o for one cycle with done_o high, in the
// first cycle with busy_o low again (the cycle after the transfer when busy_o never
// rises); the receiver cannot stall it.
module block_buffer_cache_lru
  import bbc_lru_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    logic             vld;
    logic [SW-1:0]    rank;
  } entry_t;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_OP     = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_LAST   = 6'b010000,
    ST_GET_WB = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [SW-1:0] pidx_q, pidx_d;
  logic          pv_q, pv_d;
  logic          hit_fnd_q, hit_fnd_d;
  logic          vic_fnd_q, vic_fnd_d;
  logic          done_q, done_d;
  req_t          req_q, req_d;
  logic [SW-1:0] sel_q, sel_d;
  logic [SW-1:0] old_rank_q, old_rank_d;
  logic [SW-1:0] hit_idx_q, hit_idx_d;
  logic [SW-1:0] vic_idx_q, vic_idx_d;
  entry_t        hit_ent_q, hit_ent_d;
  entry_t        vic_ent_q, vic_ent_d;
  rsp_t          rsp_q, rsp_d;

  entry_t        mem_q [SLOT_COUNT];
  entry_t        rd_q;
  logic [SW-1:0] rd_addr;
  logic          we;
  logic [SW-1:0] wr_addr;
  entry_t        wr_data;

  logic          in_range;
  logic          tag_match;

  assign in_range  = 32'(req_i.slot_in) < 32'(SLOT_COUNT);
  assign tag_match = (rd_q.dev == req_q.device) && (rd_q.blk == req_q.block_number);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    pv_d       = pv_q;
    hit_fnd_d  = hit_fnd_q;
    vic_fnd_d  = vic_fnd_q;
    req_d      = req_q;
    sel_d      = sel_q;
    old_rank_d = old_rank_q;
    hit_idx_d  = hit_idx_q;
    vic_idx_d  = vic_idx_q;
    hit_ent_d  = hit_ent_q;
    vic_ent_d  = vic_ent_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    rd_addr    = idx_q;
    we         = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_q;

    // shared compare unit: looks at the slot read in the previous cycle
    if (pv_q && (state_q == ST_SCAN || state_q == ST_LAST)) begin
      if (req_q.kind == KIND_GET) begin
        if (tag_match && (!hit_fnd_q || rd_q.rank < hit_ent_q.rank)) begin
          hit_fnd_d = 1'b1;
          hit_idx_d = pidx_q;
          hit_ent_d = rd_q;
        end
        if (rd_q.cnt == '0 && (!vic_fnd_q || rd_q.rank > vic_ent_q.rank)) begin
          vic_fnd_d = 1'b1;
          vic_idx_d = pidx_q;
          vic_ent_d = rd_q;
        end
      end else begin
        // release sweep: selected slot becomes most recent, younger ones age by one
        we      = 1'b1;
        wr_addr = pidx_q;
        wr_data = rd_q;
        if (pidx_q == sel_q) begin
          wr_data.rank = '0;
          wr_data.cnt  = '0;
        end else if (rd_q.rank < old_rank_q) begin
          wr_data.rank = rd_q.rank + 1'b1;
        end
      end
    end

    unique case (state_q)
      ST_INIT: begin
        we           = 1'b1;
        wr_addr      = idx_q;
        wr_data      = '0;
        wr_data.rank = LAST_IDX - idx_q;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        rd_addr = SW'(req_i.slot_in);
        if (start_i) begin
          req_d     = req_i;
          sel_d     = SW'(req_i.slot_in);
          idx_d     = '0;
          pv_d      = 1'b0;
          hit_fnd_d = 1'b0;
          vic_fnd_d = 1'b0;
          if (req_i.kind == KIND_GET) begin
            state_d = ST_SCAN;
          end else if (in_range) begin
            state_d = ST_OP;
          end else begin
            done_d           = 1'b1;
            rsp_d.slot_out   = req_i.slot_in;
            rsp_d.hit        = 1'b0;
            rsp_d.needs_fill = 1'b0;
            rsp_d.status     = STATUS_OK;
          end
        end
      end
      ST_OP: begin
        rsp_d.slot_out   = SLOT_W'(sel_q);
        rsp_d.hit        = 1'b0;
        rsp_d.needs_fill = 1'b0;
        rsp_d.status     = STATUS_OK;
        wr_addr          = sel_q;
        wr_data          = rd_q;
        old_rank_d       = rd_q.rank;
        state_d          = ST_IDLE;
        done_d           = 1'b1;
        if (req_q.kind == KIND_PIN) begin
          we = 1'b1;
          if (rd_q.cnt != '1) begin
            wr_data.cnt = rd_q.cnt + 1'b1;
          end
        end else if (rd_q.cnt == '0) begin
          rsp_d.status = STATUS_UNDERFLOW;
        end else if (req_q.kind == KIND_RELEASE && rd_q.cnt == CNT_W'(1)) begin
          // count reaches zero: the sweep writes the slot and sends the result
          done_d  = 1'b0;
          state_d = ST_SCAN;
        end else begin
          we          = 1'b1;
          wr_data.cnt = rd_q.cnt - 1'b1;
        end
      end
      ST_SCAN: begin
        rd_addr = idx_q;
        pv_d    = 1'b1;
        pidx_d  = idx_q;
        if (idx_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_LAST: begin
        pv_d = 1'b0;
        if (req_q.kind == KIND_GET) begin
          state_d = ST_GET_WB;
        end else begin
          state_d          = ST_IDLE;
          done_d           = 1'b1;
          rsp_d.slot_out   = SLOT_W'(sel_q);
          rsp_d.hit        = 1'b0;
          rsp_d.needs_fill = 1'b0;
          rsp_d.status     = STATUS_OK;
        end
      end
      ST_GET_WB: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if (hit_fnd_q) begin
          we          = 1'b1;
          wr_addr     = hit_idx_q;
          wr_data     = hit_ent_q;
          wr_data.vld = 1'b1;
          if (hit_ent_q.cnt != '1) begin
            wr_data.cnt = hit_ent_q.cnt + 1'b1;
          end
          rsp_d.slot_out   = SLOT_W'(hit_idx_q);
          rsp_d.hit        = 1'b1;
          rsp_d.needs_fill = ~hit_ent_q.vld;
          rsp_d.status     = STATUS_OK;
        end else if (vic_fnd_q) begin
          we          = 1'b1;
          wr_addr     = vic_idx_q;
          wr_data     = vic_ent_q;
          wr_data.dev = req_q.device;
          wr_data.blk = req_q.block_number;
          wr_data.cnt = CNT_W'(1);
          wr_data.vld = 1'b1;
          rsp_d.slot_out   = SLOT_W'(vic_idx_q);
          rsp_d.hit        = 1'b0;
          rsp_d.needs_fill = 1'b1;
          rsp_d.status     = STATUS_OK;
        end else begin
          rsp_d.slot_out   = '0;
          rsp_d.hit        = 1'b0;
          rsp_d.needs_fill = 1'b0;
          rsp_d.status     = STATUS_NO_BUF;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      idx_q     <= '0;
      pv_q      <= 1'b0;
      hit_fnd_q <= 1'b0;
      vic_fnd_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pv_q      <= pv_d;
      hit_fnd_q <= hit_fnd_d;
      vic_fnd_q <= vic_fnd_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    req_q      <= req_d;
    sel_q      <= sel_d;
    old_rank_q <= old_rank_d;
    hit_idx_q  <= hit_idx_d;
    vic_idx_q  <= vic_idx_d;
    hit_ent_q  <= hit_ent_d;
    vic_ent_q  <= vic_ent_d;
    rsp_q      <= rsp_d;
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
